// ----- rtl/spcw_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes for the segment pair coordinate warp.
// Used by spcw_setup, spcw_div and the top level; depends on nothing.
package spcw_pkg;

  // Field and datapath sizes
  localparam int FIELD_W     = 12;
  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 8;
  localparam int LEN_FRAC    = 8;
  localparam int OUT_W       = 21;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // Segment deltas, squared lengths and products
  localparam int DELTA_W  = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DELTA_W;
  localparam int SQ_W     = 2 * COORD_BITS + 1;
  localparam int MPROD_W  = SQ_W + COORD_BITS;

  // Length square root: operand carries 2*LEN_FRAC fraction bits
  localparam int SQIN_W   = SQ_W + 2 * LEN_FRAC;
  localparam int SQ_ITER  = (SQIN_W + 1) / 2;
  localparam int ROOT_W   = SQ_ITER;
  localparam int RES_W    = SQIN_W + 1;
  localparam int SQ_CNT_W = $clog2(SQ_ITER);
  localparam int DEN_W    = 2 * ROOT_W;

  // Pipelined divider
  localparam int NUM_W      = MPROD_W + FRAC_BITS + 2 * LEN_FRAC + 1;
  localparam int QUO_W      = 2 * COORD_BITS + FRAC_BITS + 2;
  localparam int DIV_STAGES = QUO_W;
  localparam int LANES      = 4;

  // Final sum and saturation bounds
  localparam int SUM_W = QUO_W + 3;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (OUT_W - 1)));

  // Register indexes
  localparam int REG_BEFORE_START_X = 0;
  localparam int REG_BEFORE_START_Y = 1;
  localparam int REG_BEFORE_END_X   = 2;
  localparam int REG_BEFORE_END_Y   = 3;
  localparam int REG_AFTER_START_X  = 4;
  localparam int REG_AFTER_START_Y  = 5;
  localparam int REG_AFTER_END_X    = 6;
  localparam int REG_AFTER_END_Y    = 7;

  // Divider lanes: along-segment and across-segment terms for x and y
  localparam int LANE_X_ALONG  = 0;
  localparam int LANE_X_ACROSS = 1;
  localparam int LANE_Y_ALONG  = 2;
  localparam int LANE_Y_ACROSS = 3;

  typedef logic [LANES-1:0][NUM_W-1:0] num_lanes_t;
  typedef logic [LANES-1:0][QUO_W-1:0] quo_lanes_t;
  typedef logic [LANES-1:0][DEN_W-1:0] den_lanes_t;

  typedef struct packed {
    logic rd_neg;
    logic rn_neg;
  } side_t;

  typedef struct packed {
    logic             busy;
    logic             degenerate;
    logic [SQ_W-1:0]  len_sq_after;
    logic [DEN_W-1:0] den;
  } setup_stat_t;

  typedef enum logic [2:0] {
    SU_LOAD,
    SU_ROOT_A,
    SU_ROOT_B,
    SU_MUL,
    SU_DONE
  } setup_state_t;

endpackage

// ----- rtl/segment_pair_coordinate_warp.sv -----
`timescale 1ns / 1ps
// Top level of the single line-pair coordinate warp: configuration
// registers, front pipeline, divider and output stage.
// Depends on spcw_pkg, spcw_setup and spcw_div.
//
//  channel | direction | ports                         | contents (lowest bit up)
//  in_     | slave     | in_tvalid/tready/tdata        | pixel_x[11:0], pixel_y[23:12]
//  out_    | master    | out_tvalid/tready/tdata/tuser | source_x, source_y; tuser degenerate
//  cfg_    | slave     | cfg_valid/ready/index/data    | register index, 12-bit value
//
// One pixel is accepted per cycle while the setup is idle and the output is not stalled;
// each result passes through six front stages, the first loaded by the accepting edge,
// a 34-stage divider and one output stage.
// After reset and after every configuration write the length setup runs
// (square roots take one bit per cycle), with in_tready low.
// A stalled output holds the whole pipe; cfg_ready is always high.
module segment_pair_coordinate_warp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [spcw_pkg::IN_TDATA_W-1:0]      in_tdata,   // pixel_x, pixel_y
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [spcw_pkg::OUT_TDATA_W-1:0]     out_tdata,  // source_x, source_y, zero pad
  output logic                                 out_tuser,  // degenerate
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import spcw_pkg::*;

  logic [COORD_BITS-1:0] cfg_regs_r [NUM_REGS];
  logic                  cfg_wr;
  setup_stat_t           stat;

  logic signed [DELTA_W-1:0] adx, ady, bdx, bdy;
  logic [COORD_BITS-1:0]     bdx_mag, bdy_mag;
  logic                      bdx_neg, bdy_neg, bdy_pos;
  logic                      en, in_acc;

  // Configuration writes; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs_r[i] <= '0;
      end
    end else if (cfg_wr && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_regs_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data[COORD_BITS-1:0];
    end
  end

  // Segment deltas
  assign adx = $signed({1'b0, cfg_regs_r[REG_AFTER_END_X]})
             - $signed({1'b0, cfg_regs_r[REG_AFTER_START_X]});
  assign ady = $signed({1'b0, cfg_regs_r[REG_AFTER_END_Y]})
             - $signed({1'b0, cfg_regs_r[REG_AFTER_START_Y]});
  assign bdx = $signed({1'b0, cfg_regs_r[REG_BEFORE_END_X]})
             - $signed({1'b0, cfg_regs_r[REG_BEFORE_START_X]});
  assign bdy = $signed({1'b0, cfg_regs_r[REG_BEFORE_END_Y]})
             - $signed({1'b0, cfg_regs_r[REG_BEFORE_START_Y]});

  assign bdx_neg = bdx[DELTA_W-1];
  assign bdy_neg = bdy[DELTA_W-1];
  assign bdy_pos = !bdy[DELTA_W-1] && (bdy != '0);
  assign bdx_mag = bdx_neg ? COORD_BITS'(-bdx) : bdx[COORD_BITS-1:0];
  assign bdy_mag = bdy_neg ? COORD_BITS'(-bdy) : bdy[COORD_BITS-1:0];

  spcw_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .adx   (adx),
    .ady   (ady),
    .bdx   (bdx),
    .bdy   (bdy),
    .stat  (stat)
  );

  // Pipe enable: move when the output stage is empty or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && !stat.busy;
  assign in_acc    = in_tvalid && in_tready;

  // Stage A: capture pixel
  logic                  a_valid_r;
  logic [COORD_BITS-1:0] a_px_r, a_py_r;
  // Stage B: offset from the after segment start
  logic                      b_valid_r;
  logic signed [DELTA_W-1:0] b_rx_r, b_ry_r;
  // Stage C: cross products
  logic                     c_valid_r;
  logic signed [PROD_W-1:0] c_xx_r, c_yy_r, c_yx_r, c_xy_r;
  // Stage D: along and across projections as magnitude and sign
  logic                   d_valid_r;
  logic [SQ_W-1:0]        d_rd_mag_r, d_rn_mag_r;
  side_t                  d_side_r;
  logic signed [PROD_W:0] rd_sum, rn_sum;
  // Stage E: scaled by the before segment
  logic                              e_valid_r;
  logic [LANES-1:0][MPROD_W-1:0]     e_prod_r;
  side_t                             e_side_r;
  // Stage F: divider numerators
  logic       f_valid_r;
  num_lanes_t f_num_r;
  side_t      f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_acc;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      e_valid_r <= d_valid_r;
      f_valid_r <= e_valid_r;
    end
  end

  assign rd_sum = c_xx_r + c_yy_r;
  assign rn_sum = c_yx_r - c_xy_r;

  // Front pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r <= in_tdata[COORD_BITS-1:0];
      a_py_r <= in_tdata[FIELD_W+COORD_BITS-1:FIELD_W];

      b_rx_r <= $signed({1'b0, a_px_r}) - $signed({1'b0, cfg_regs_r[REG_AFTER_START_X]});
      b_ry_r <= $signed({1'b0, a_py_r}) - $signed({1'b0, cfg_regs_r[REG_AFTER_START_Y]});

      c_xx_r <= b_rx_r * adx;
      c_yy_r <= b_ry_r * ady;
      c_yx_r <= b_ry_r * adx;
      c_xy_r <= b_rx_r * ady;

      d_rd_mag_r      <= rd_sum[PROD_W] ? SQ_W'(-rd_sum) : SQ_W'(rd_sum);
      d_rn_mag_r      <= rn_sum[PROD_W] ? SQ_W'(-rn_sum) : SQ_W'(rn_sum);
      d_side_r.rd_neg <= rd_sum[PROD_W];
      d_side_r.rn_neg <= rn_sum[PROD_W];

      e_prod_r[LANE_X_ALONG]  <= MPROD_W'(d_rd_mag_r * bdx_mag);
      e_prod_r[LANE_X_ACROSS] <= MPROD_W'(d_rn_mag_r * bdy_mag);
      e_prod_r[LANE_Y_ALONG]  <= MPROD_W'(d_rd_mag_r * bdy_mag);
      e_prod_r[LANE_Y_ACROSS] <= MPROD_W'(d_rn_mag_r * bdx_mag);
      e_side_r                <= d_side_r;

      // Add half the divisor so the divider rounds half up
      f_num_r[LANE_X_ALONG]  <= NUM_W'({e_prod_r[LANE_X_ALONG], {FRAC_BITS{1'b0}}})
                              + NUM_W'(stat.len_sq_after >> 1);
      f_num_r[LANE_Y_ALONG]  <= NUM_W'({e_prod_r[LANE_Y_ALONG], {FRAC_BITS{1'b0}}})
                              + NUM_W'(stat.len_sq_after >> 1);
      f_num_r[LANE_X_ACROSS] <= NUM_W'({e_prod_r[LANE_X_ACROSS],
                                        {(FRAC_BITS + 2 * LEN_FRAC){1'b0}}})
                              + NUM_W'(stat.den >> 1);
      f_num_r[LANE_Y_ACROSS] <= NUM_W'({e_prod_r[LANE_Y_ACROSS],
                                        {(FRAC_BITS + 2 * LEN_FRAC){1'b0}}})
                              + NUM_W'(stat.den >> 1);
      f_side_r <= e_side_r;
    end
  end

  // Divide
  den_lanes_t divisor;
  logic       div_valid;
  quo_lanes_t div_quo;
  side_t      div_side;

  assign divisor[LANE_X_ALONG]  = DEN_W'(stat.len_sq_after);
  assign divisor[LANE_Y_ALONG]  = DEN_W'(stat.len_sq_after);
  assign divisor[LANE_X_ACROSS] = stat.den;
  assign divisor[LANE_Y_ACROSS] = stat.den;

  spcw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid_r),
    .in_num    (f_num_r),
    .in_side   (f_side_r),
    .divisor   (divisor),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // Apply signs, add the before segment start, saturate
  logic [LANES-1:0]              lane_neg;
  logic signed [SUM_W-1:0]       term [LANES];
  logic signed [SUM_W-1:0]       sx, sy;
  logic [OUT_W-1:0]              sx_sat, sy_sat;

  assign lane_neg[LANE_X_ALONG]  = div_side.rd_neg ^ bdx_neg;
  assign lane_neg[LANE_X_ACROSS] = div_side.rn_neg ^ bdy_pos;
  assign lane_neg[LANE_Y_ALONG]  = div_side.rd_neg ^ bdy_neg;
  assign lane_neg[LANE_Y_ACROSS] = div_side.rn_neg ^ bdx_neg;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      term[l] = lane_neg[l] ? -$signed(SUM_W'(div_quo[l])) : $signed(SUM_W'(div_quo[l]));
    end
  end

  assign sx = $signed(SUM_W'({cfg_regs_r[REG_BEFORE_START_X], {FRAC_BITS{1'b0}}}))
            + term[LANE_X_ALONG] + term[LANE_X_ACROSS];
  assign sy = $signed(SUM_W'({cfg_regs_r[REG_BEFORE_START_Y], {FRAC_BITS{1'b0}}}))
            + term[LANE_Y_ALONG] + term[LANE_Y_ACROSS];

  always_comb begin
    priority if (sx > SAT_HI) begin
      sx_sat = SAT_HI[OUT_W-1:0];
    end else if (sx < SAT_LO) begin
      sx_sat = SAT_LO[OUT_W-1:0];
    end else begin
      sx_sat = sx[OUT_W-1:0];
    end
    priority if (sy > SAT_HI) begin
      sy_sat = SAT_HI[OUT_W-1:0];
    end else if (sy < SAT_LO) begin
      sy_sat = SAT_LO[OUT_W-1:0];
    end else begin
      sy_sat = sy[OUT_W-1:0];
    end
  end

  // Output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_x_r, out_y_r;
  logic             out_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= stat.degenerate ? '0 : sx_sat;
      out_y_r   <= stat.degenerate ? '0 : sy_sat;
      out_deg_r <= stat.degenerate;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * OUT_W){1'b0}}, out_y_r, out_x_r};
  assign out_tuser  = out_deg_r;

endmodule

// ----- rtl/spcw_setup.sv -----
`timescale 1ns / 1ps
// Per-configuration setup: squared segment lengths, their square roots
// and the across-term divisor. Depends on spcw_pkg.
module spcw_setup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [spcw_pkg::DELTA_W-1:0] adx,
  input  logic signed [spcw_pkg::DELTA_W-1:0] ady,
  input  logic signed [spcw_pkg::DELTA_W-1:0] bdx,
  input  logic signed [spcw_pkg::DELTA_W-1:0] bdy,
  output spcw_pkg::setup_stat_t               stat
);
  import spcw_pkg::*;

  localparam logic [SQIN_W-1:0] BIT_INIT = SQIN_W'(1) << (2 * (SQ_ITER - 1));

  setup_state_t state_r, state_nxt;

  logic [SQ_W-1:0]     la2_r, lb2_r;
  logic [SQ_W-1:0]     la2_nxt, lb2_nxt;
  logic [SQIN_W-1:0]   v_r, bit_r;
  logic [RES_W-1:0]    res_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [ROOT_W-1:0]   lena_r, lenb_r;
  logic [DEN_W-1:0]    den_r;

  logic signed [PROD_W-1:0] adx_sq, ady_sq, bdx_sq, bdy_sq;
  logic [RES_W-1:0]    trial;
  logic                take;
  logic [SQIN_W-1:0]   v_step;
  logic [RES_W-1:0]    res_step;

  logic load, step, last, mul, busy;

  // Squared lengths of both segments
  assign adx_sq  = adx * adx;
  assign ady_sq  = ady * ady;
  assign bdx_sq  = bdx * bdx;
  assign bdy_sq  = bdy * bdy;
  assign la2_nxt = SQ_W'(adx_sq + ady_sq);
  assign lb2_nxt = SQ_W'(bdx_sq + bdy_sq);

  // One square-root digit per cycle
  assign trial    = res_r + RES_W'(bit_r);
  assign take     = {1'b0, v_r} >= trial;
  assign v_step   = take ? SQIN_W'({1'b0, v_r} - trial) : v_r;
  assign res_step = take ? (res_r >> 1) + RES_W'(bit_r) : (res_r >> 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = SU_LOAD;
    end else begin
      unique case (state_r)
        SU_LOAD:   state_nxt = SU_ROOT_A;
        SU_ROOT_A: if (last) state_nxt = SU_ROOT_B;
        SU_ROOT_B: if (last) state_nxt = SU_MUL;
        SU_MUL:    state_nxt = SU_DONE;
        SU_DONE:   state_nxt = SU_DONE;
        default:   state_nxt = SU_LOAD;
      endcase
    end
  end

  // Sequencer outputs
  always_comb begin
    load = 1'b0;
    step = 1'b0;
    mul  = 1'b0;
    busy = 1'b1;
    last = (cnt_r == SQ_CNT_W'(SQ_ITER - 1));
    unique case (state_r)
      SU_LOAD:   load = 1'b1;
      SU_ROOT_A: step = 1'b1;
      SU_ROOT_B: step = 1'b1;
      SU_MUL:    mul  = 1'b1;
      SU_DONE:   busy = 1'b0;
      default:   load = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load, iterate and capture the two roots, then form the divisor
  always_ff @(posedge clk) begin
    if (load) begin
      la2_r <= la2_nxt;
      lb2_r <= lb2_nxt;
      v_r   <= {la2_nxt, {(2 * LEN_FRAC){1'b0}}};
      res_r <= '0;
      bit_r <= BIT_INIT;
      cnt_r <= '0;
    end else if (step) begin
      if (last) begin
        if (state_r == SU_ROOT_A) begin
          lena_r <= res_step[ROOT_W-1:0];
        end else begin
          lenb_r <= res_step[ROOT_W-1:0];
        end
        v_r   <= {lb2_r, {(2 * LEN_FRAC){1'b0}}};
        res_r <= '0;
        bit_r <= BIT_INIT;
        cnt_r <= '0;
      end else begin
        v_r   <= v_step;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (mul) begin
      den_r <= lena_r * lenb_r;
    end
  end

  assign stat.busy         = busy;
  assign stat.degenerate   = (la2_r == '0) || (lb2_r == '0);
  assign stat.len_sq_after = la2_r;
  assign stat.den          = den_r;

endmodule

// ----- rtl/spcw_div.sv -----
`timescale 1ns / 1ps
// Four-lane restoring divider, one quotient bit per register stage,
// with rounding offset already in the numerator. Depends on spcw_pkg.
module spcw_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  spcw_pkg::num_lanes_t   in_num,
  input  spcw_pkg::side_t        in_side,
  input  spcw_pkg::den_lanes_t   divisor,
  output logic                   out_valid,
  output spcw_pkg::quo_lanes_t   out_quo,
  output spcw_pkg::side_t        out_side
);
  import spcw_pkg::*;

  logic [DIV_STAGES-1:0] valid_r;
  logic [DEN_W-1:0] rem_r    [DIV_STAGES][LANES];
  logic [QUO_W-1:0] work_r   [DIV_STAGES][LANES];
  logic [DEN_W-1:0] rem_nxt  [DIV_STAGES][LANES];
  logic [QUO_W-1:0] work_nxt [DIV_STAGES][LANES];
  side_t            side_r   [DIV_STAGES];

  // Each stage shifts one numerator bit into the remainder and one
  // quotient bit into the low end of the work word
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] work_in;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;
      if (k == 0) begin : g_first
        assign rem_in  = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
        assign work_in = in_num[l][QUO_W-1:0];
      end else begin : g_next
        assign rem_in  = rem_r[k-1][l];
        assign work_in = work_r[k-1][l];
      end
      assign trial = {rem_in, work_in[QUO_W-1]};
      assign diff  = trial - {1'b0, divisor[l]};
      assign take  = trial >= {1'b0, divisor[l]};
      assign rem_nxt[k][l]  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign work_nxt[k][l] = {work_in[QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DIV_STAGES-2:0], in_valid};
    end
  end

  // Advance the whole pipe on enable
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l]  <= rem_nxt[k][l];
          work_r[k][l] <= work_nxt[k][l];
        end
      end
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = work_r[DIV_STAGES-1][l];
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule
